>>> rtl/packet_mode_checker_reassembler_assert.svh
// Assertion macros for the packet-mode checker and reassembler.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef PACKET_MODE_CHECKER_REASSEMBLER_ASSERT_SVH
`define PACKET_MODE_CHECKER_REASSEMBLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define PMCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmcr assertion failed");
// Next-cycle implication, checked out of reset.
`define PMCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmcr assertion failed");
`else
`define PMCR_ASSERT_NOW(label, ante, cons)
`define PMCR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/pmcr_pkg.sv
// Shared types and constants for the packet-mode checker and reassembler.
// No dependencies.
package pmcr_pkg;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_CRC_FAIL  = 3'd0,
    VERDICT_LEN_ERR   = 3'd1,
    VERDICT_SINGLE    = 3'd2,
    VERDICT_STARTED   = 3'd3,
    VERDICT_APPENDED  = 3'd4,
    VERDICT_COMPLETED = 3'd5,
    VERDICT_ABORTED   = 3'd6
  } verdict_e;

  // First/last flag codes from header byte 0
  localparam logic [1:0] LOC_INTERMEDIATE = 2'd0;
  localparam logic [1:0] LOC_LAST         = 2'd1;
  localparam logic [1:0] LOC_FIRST        = 2'd2;
  localparam logic [1:0] LOC_SINGLE       = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_XOR  = 16'hFFFF;

  localparam int unsigned HDR_BYTES = 3;
  localparam int unsigned CRC_BYTES = 2;

  // Packet length in bytes, indexed by the length id
  localparam logic [6:0] PACKET_LEN [4] = '{7'd24, 7'd48, 7'd72, 7'd96};

  localparam logic [7:0] PKT_COUNT_MAX = 8'hFF;

endpackage

>>> rtl/pmcr_if.sv
// Stream channels of the packet-mode checker: byte input and result output.
// Depends on pmcr_pkg.
interface pmcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       packet_start;

  modport source (output valid, stream_byte, packet_start, input ready);
  modport sink   (input valid, stream_byte, packet_start, output ready);
endinterface

interface pmcr_out_if;
  logic                valid;
  logic                ready;
  pmcr_pkg::kind_e     result_kind;
  logic [7:0]          data_byte;
  pmcr_pkg::verdict_e  verdict;
  logic [9:0]          packet_address;
  logic [6:0]          useful_length;
  logic                continuity_ok;
  logic [7:0]          group_packets;
  logic [15:0]         group_bytes;

  modport source (output valid, result_kind, data_byte, verdict, packet_address,
                  useful_length, continuity_ok, group_packets, group_bytes,
                  input ready);
  modport sink   (input valid, result_kind, data_byte, verdict, packet_address,
                  useful_length, continuity_ok, group_packets, group_bytes,
                  output ready);
endinterface

>>> rtl/pmcr_crc16.sv
// Bytewise CRC-16 update, MSB first, polynomial from pmcr_pkg.
// Depends on pmcr_pkg.
module pmcr_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    logic        fb;
    c = crc_i;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data_i[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ pmcr_pkg::CRC_POLY;
      end
    end
    crc_o = c;
  end

endmodule

>>> rtl/packet_mode_checker_reassembler.sv
// Packet-mode network-level checker and reassembler, top level.
// Depends on pmcr_pkg, pmcr_if, pmcr_crc16 and the assertion macro header.
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  ---------------------------------------------
//  in_i      in   valid/ready    stream_byte[7:0], packet_start
//  out_o     out  valid/ready    result_kind, data_byte, verdict, packet_address,
//                                useful_length, continuity_ok, group_packets,
//                                group_bytes
//
// One byte per cycle while out_o is not stalled: each accepted request yields
// exactly one result, held in the result register from the cycle after it.
// The byte-wide CRC update and group counters feed that register combinationally.
// A request is taken while the result register is empty or being drained,
// so a stall on out_o stalls in_i by one register and no more.
// Reset (rst_ni low, asynchronous) leaves the block between packets, no group open.

`include "packet_mode_checker_reassembler_assert.svh"

module packet_mode_checker_reassembler #(
  parameter int unsigned GROUP_BYTES_MAX = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmcr_in_if.sink     in_i,
  pmcr_out_if.source  out_o
);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  logic in_fire;

  // Take a new request when the result slot is free or drains this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Packet and group state
  // ---------------------------------------------------------------------------
  logic [6:0]  pos_q, pos_d;
  logic        in_packet_q, in_packet_d;
  logic [7:0]  hdr0_q, hdr0_d;       // length id, continuity, flags, address high
  logic [7:0]  hdr1_q, hdr1_d;       // address low
  logic [6:0]  useful_q, useful_d;   // useful data length
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [1:0]  prev_cont_q, prev_cont_d;
  logic        grp_open_q, grp_open_d;
  logic [9:0]  grp_addr_q, grp_addr_d;
  logic [7:0]  grp_pkts_q, grp_pkts_d;
  logic [15:0] grp_bytes_q, grp_bytes_d;

  // Result payload
  pmcr_pkg::kind_e    kind_q, kind_d;
  logic [7:0]         data_q, data_d;
  pmcr_pkg::verdict_e verdict_q, verdict_d;
  logic [9:0]         addr_out_q, addr_out_d;
  logic [6:0]         useful_out_q, useful_out_d;
  logic               cont_ok_q, cont_ok_d;
  logic [7:0]         rep_pkts_q, rep_pkts_d;
  logic [15:0]        rep_bytes_q, rep_bytes_d;

  // ---------------------------------------------------------------------------
  // Datapath terms
  // ---------------------------------------------------------------------------
  logic [7:0]  b;
  logic        start;
  logic        active;
  logic [6:0]  pos;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [6:0]  plen;
  logic [6:0]  data_end;       // position of the high CRC byte
  logic        len_err;
  logic [9:0]  addr;
  logic [1:0]  cont;
  logic [1:0]  loc;
  logic        cont_ok;
  logic        crc_ok;
  logic [7:0]  pkts_push;
  logic [16:0] bytes_sum;
  logic [15:0] bytes_push;

  assign b        = in_i.stream_byte;
  assign start    = in_i.packet_start;
  assign active   = start || in_packet_q;
  assign pos      = start ? 7'd0 : pos_q;
  // A start restarts the CRC from its initial value on this byte
  assign crc_base = start ? pmcr_pkg::CRC_INIT : crc_q;

  pmcr_crc16 u_crc (
    .crc_i  (crc_base),
    .data_i (b),
    .crc_o  (crc_next)
  );

  assign plen     = pmcr_pkg::PACKET_LEN[hdr0_q[7:6]];
  assign data_end = plen - 7'(pmcr_pkg::CRC_BYTES);
  // Useful length must fit the data field (packet minus header and CRC)
  assign len_err  = useful_q > (plen - 7'(pmcr_pkg::HDR_BYTES + pmcr_pkg::CRC_BYTES));

  assign addr    = {hdr0_q[1:0], hdr1_q};
  assign cont    = hdr0_q[5:4];
  assign loc     = hdr0_q[3:2];
  assign cont_ok = (cont == 2'(prev_cont_q + 2'd1));
  assign crc_ok  = ({crc_hi_q, b} == (crc_q ^ pmcr_pkg::CRC_XOR));

  // Group push: packet count stops at its maximum, byte count at GROUP_BYTES_MAX
  assign pkts_push  = (grp_pkts_q != pmcr_pkg::PKT_COUNT_MAX) ? grp_pkts_q + 8'd1 : grp_pkts_q;
  assign bytes_sum  = {1'b0, grp_bytes_q} + {10'd0, useful_q};
  assign bytes_push = (bytes_sum > 17'(GROUP_BYTES_MAX)) ? 16'(GROUP_BYTES_MAX)
                                                         : bytes_sum[15:0];

  // ---------------------------------------------------------------------------
  // Next state and result for the byte on the input
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_d        = pos_q;
    in_packet_d  = in_packet_q;
    hdr0_d       = hdr0_q;
    hdr1_d       = hdr1_q;
    useful_d     = useful_q;
    crc_d        = crc_q;
    crc_hi_d     = crc_hi_q;
    prev_cont_d  = prev_cont_q;
    grp_open_d   = grp_open_q;
    grp_addr_d   = grp_addr_q;
    grp_pkts_d   = grp_pkts_q;
    grp_bytes_d  = grp_bytes_q;

    kind_d       = pmcr_pkg::KIND_NONE;
    data_d       = 8'd0;
    verdict_d    = pmcr_pkg::VERDICT_CRC_FAIL;
    addr_out_d   = 10'd0;
    useful_out_d = 7'd0;
    cont_ok_d    = 1'b0;
    rep_pkts_d   = 8'd0;
    rep_bytes_d  = 16'd0;

    if (active) begin
      if (start) begin
        // Drop any partial packet and begin a new one
        in_packet_d = 1'b1;
        crc_d       = pmcr_pkg::CRC_INIT;
        hdr1_d      = 8'd0;
        useful_d    = 7'd0;
        crc_hi_d    = 8'd0;
      end

      if (pos < 7'(pmcr_pkg::HDR_BYTES)) begin
        // Header byte: capture and run through the CRC
        case (pos[1:0])
          2'd0:    hdr0_d   = b;
          2'd1:    hdr1_d   = b;
          default: useful_d = b[6:0];
        endcase
        crc_d = crc_next;
        pos_d = pos + 7'd1;
      end else if (pos < data_end) begin
        // Data field: CRC it and echo the useful part
        crc_d = crc_next;
        if (!len_err && ((pos - 7'(pmcr_pkg::HDR_BYTES)) < useful_q)) begin
          kind_d = pmcr_pkg::KIND_DATA;
          data_d = b;
        end
        pos_d = pos + 7'd1;
      end else if (pos == data_end) begin
        // Hold the high CRC byte until the last one arrives
        crc_hi_d = b;
        pos_d    = pos + 7'd1;
      end else begin
        // Last byte: give the verdict
        in_packet_d  = 1'b0;
        pos_d        = 7'd0;
        kind_d       = pmcr_pkg::KIND_VERDICT;
        addr_out_d   = addr;
        useful_out_d = useful_q;
        cont_ok_d    = cont_ok;
        rep_pkts_d   = grp_pkts_q;
        rep_bytes_d  = grp_bytes_q;

        if (len_err) begin
          verdict_d = pmcr_pkg::VERDICT_LEN_ERR;
        end else if (!crc_ok) begin
          verdict_d = pmcr_pkg::VERDICT_CRC_FAIL;
        end else begin
          prev_cont_d = cont;
          case (loc)
            pmcr_pkg::LOC_SINGLE: begin
              verdict_d = pmcr_pkg::VERDICT_SINGLE;
            end
            pmcr_pkg::LOC_FIRST: begin
              // Restart the group on this packet
              grp_open_d  = 1'b1;
              grp_addr_d  = addr;
              grp_pkts_d  = 8'd1;
              grp_bytes_d = {9'd0, useful_q};
              rep_pkts_d  = 8'd1;
              rep_bytes_d = {9'd0, useful_q};
              verdict_d   = pmcr_pkg::VERDICT_STARTED;
            end
            default: begin
              if (!grp_open_q || (grp_addr_q != addr) || !cont_ok) begin
                // Group broken: drop it and report zero counts
                grp_open_d  = 1'b0;
                grp_addr_d  = 10'd0;
                grp_pkts_d  = 8'd0;
                grp_bytes_d = 16'd0;
                rep_pkts_d  = 8'd0;
                rep_bytes_d = 16'd0;
                verdict_d   = pmcr_pkg::VERDICT_ABORTED;
              end else begin
                rep_pkts_d  = pkts_push;
                rep_bytes_d = bytes_push;
                if (loc == pmcr_pkg::LOC_INTERMEDIATE) begin
                  grp_pkts_d  = pkts_push;
                  grp_bytes_d = bytes_push;
                  verdict_d   = pmcr_pkg::VERDICT_APPENDED;
                end else begin
                  // Report the totals, then close the group
                  grp_open_d  = 1'b0;
                  grp_addr_d  = 10'd0;
                  grp_pkts_d  = 8'd0;
                  grp_bytes_d = 16'd0;
                  verdict_d   = pmcr_pkg::VERDICT_COMPLETED;
                end
              end
            end
          endcase
        end
      end
    end
  end

  // Set the result slot on a request, clear it once taken
  always_comb begin
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 7'd0;
      in_packet_q <= 1'b0;
      hdr0_q      <= 8'd0;
      hdr1_q      <= 8'd0;
      useful_q    <= 7'd0;
      crc_q       <= pmcr_pkg::CRC_INIT;
      crc_hi_q    <= 8'd0;
      prev_cont_q <= 2'd0;
      grp_open_q  <= 1'b0;
      grp_addr_q  <= 10'd0;
      grp_pkts_q  <= 8'd0;
      grp_bytes_q <= 16'd0;
    end else begin
      out_valid_q <= out_valid_d;
      // Advance packet and group state only on an accepted request
      if (in_fire) begin
        pos_q       <= pos_d;
        in_packet_q <= in_packet_d;
        hdr0_q      <= hdr0_d;
        hdr1_q      <= hdr1_d;
        useful_q    <= useful_d;
        crc_q       <= crc_d;
        crc_hi_q    <= crc_hi_d;
        prev_cont_q <= prev_cont_d;
        grp_open_q  <= grp_open_d;
        grp_addr_q  <= grp_addr_d;
        grp_pkts_q  <= grp_pkts_d;
        grp_bytes_q <= grp_bytes_d;
      end
    end
  end

  // Result payload: load on a request, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q       <= kind_d;
      data_q       <= data_d;
      verdict_q    <= verdict_d;
      addr_out_q   <= addr_out_d;
      useful_out_q <= useful_out_d;
      cont_ok_q    <= cont_ok_d;
      rep_pkts_q   <= rep_pkts_d;
      rep_bytes_q  <= rep_bytes_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = kind_q;
  assign out_o.data_byte      = data_q;
  assign out_o.verdict        = verdict_q;
  assign out_o.packet_address = addr_out_q;
  assign out_o.useful_length  = useful_out_q;
  assign out_o.continuity_ok  = cont_ok_q;
  assign out_o.group_packets  = rep_pkts_q;
  assign out_o.group_bytes    = rep_bytes_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Between packets the byte position rests at zero
  `PMCR_ASSERT_NOW(a_idle_pos_zero, !in_packet_q, pos_q == 7'd0)
  // Past the header the position never runs beyond the packet length
  `PMCR_ASSERT_NOW(a_pos_in_packet, in_packet_q && (pos_q >= 7'd3), pos_q < plen)
  // No group open means no counts carried
  `PMCR_ASSERT_NOW(a_closed_group_empty, !grp_open_q,
                   (grp_pkts_q == 8'd0) && (grp_bytes_q == 16'd0) && (grp_addr_q == 10'd0))
  // Every accepted request leaves a result in the output slot
  `PMCR_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_q)

endmodule
